@@ src/edf_pkg.sv @@
// Shared types, constants and codes for the EDF job scheduler.
`default_nettype none
package edf_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic CMD_RELEASE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [2:0] {
        EV_START    = 3'd0,
        EV_RESUME   = 3'd1,
        EV_FINISH   = 3'd2,
        EV_MISS     = 3'd3,
        EV_PREEMPT  = 3'd4,
        EV_IDLE     = 3'd5,
        EV_ACCEPTED = 3'd6,
        EV_REJECTED = 3'd7
    } t_evk;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REL,
        ST_SCAN,
        ST_PICK,
        ST_IDLE_EV,
        ST_PRE,
        ST_START,
        ST_RUN,
        ST_FIN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic        command;
        logic [7:0]  task_id;
        logic [15:0] exec_time;
        logic [15:0] rel_deadline;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [3:0]  slot_index;
        logic [7:0]  event_task;
        logic [31:0] event_time;
        logic [15:0] remaining_out;
        logic [31:0] waiting_out;
        logic        last_event;
    } t_out_item;

    // best candidate handed along the chain
    typedef struct packed {
        logic              v;
        logic [SLOT_W-1:0] idx;
        logic [31:0]       dl;
        logic [31:0]       rel;
    } t_best;

    // contents of one slot as seen by the sequencer
    typedef struct packed {
        logic        valid;
        logic [7:0]  task_id;
        logic [15:0] exec;
        logic [15:0] rem;
        logic [31:0] rel;
        logic [31:0] dl;
        logic        started;
    } t_view;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              scan;
        logic [SLOT_W-1:0] pos;
        logic [31:0]       now;
        logic              run_v;
        logic [SLOT_W-1:0] run_idx;
        logic [SLOT_W-1:0] tgt_idx;
        logic              wr;
        logic [7:0]        wr_task;
        logic [15:0]       wr_exec;
        logic [31:0]       wr_dl;
        logic              dec;
        logic              start;
        logic              clr;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ src/edf_cell.sv @@
// One job table slot: holds the job and passes the best candidate to its neighbor.
`default_nettype none
module edf_cell import edf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SLOT_W-1:0] i_idx,
    input  wire t_cell_ctl         i_ctl,
    input  wire t_best             i_best,
    output t_best                  o_best,
    output t_view                  o_view
);

    logic        r_valid;
    logic [7:0]  r_task;
    logic [15:0] r_exec;
    logic [15:0] r_rem;
    logic [31:0] r_rel;
    logic [31:0] r_dl;
    logic        r_started;
    t_best       r_best;

    logic  act;
    logic  tgt;
    logic  miss;
    logic  cand;
    logic  beats;
    t_best n_best;

    assign act  = i_ctl.scan && (i_ctl.pos == i_idx);
    assign tgt  = (i_ctl.tgt_idx == i_idx);
    assign miss = r_valid && (r_dl <= i_ctl.now);
    assign cand = r_valid && !miss;

    always_comb begin
        if (!i_best.v) begin
            beats = 1'b1;
        end else if (r_dl != i_best.dl) begin
            beats = r_dl < i_best.dl;
        end else if (i_ctl.run_v && i_ctl.run_idx == i_best.idx) begin
            beats = 1'b0;
        end else if (i_ctl.run_v && i_ctl.run_idx == i_idx) begin
            beats = 1'b1;
        end else begin
            beats = r_rel > i_best.rel;
        end
    end

    always_comb begin
        n_best = i_best;
        if (cand && beats) begin
            n_best.v   = 1'b1;
            n_best.idx = i_idx;
            n_best.dl  = r_dl;
            n_best.rel = r_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (act && miss) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr && tgt) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr && tgt) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_best <= n_best;
        end
        if (i_ctl.wr && tgt) begin
            r_task    <= i_ctl.wr_task;
            r_exec    <= i_ctl.wr_exec;
            r_rem     <= i_ctl.wr_exec;
            r_rel     <= i_ctl.now;
            r_dl      <= i_ctl.wr_dl;
            r_started <= 1'b0;
        end
        if (i_ctl.dec && tgt) begin
            r_rem <= r_rem - 16'd1;
        end
        if (i_ctl.start && tgt) begin
            r_started <= 1'b1;
        end
    end

    assign o_best = r_best;

    always_comb begin
        o_view.valid   = r_valid;
        o_view.task_id = r_task;
        o_view.exec    = r_exec;
        o_view.rem     = r_rem;
        o_view.rel     = r_rel;
        o_view.dl      = r_dl;
        o_view.started = r_started;
    end

endmodule
`default_nettype wire

@@ src/edf_job_scheduler.sv @@
// Top level of the preemptive earliest-deadline-first job scheduler.
// Usage: one input channel (i_in_valid / o_in_ready / i_in_data) takes either a
// job release or a time tick; one output channel (o_out_valid / i_out_ready /
// o_out_data) delivers the resulting events, last_event set on the final one.
// Job slots live in a row of cells; a tick sweeps a token along the row, one
// cell per cycle while no miss event waits on a stalled output, checking deadline
// misses and carrying the best candidate to the next cell.
// A release passes through a write step and a flush step before its transfer-in is
// freed again; a tick sweeps the cell row, picks a job, then takes the idle or the
// preempt, start, run and finish steps as needed before its flush step.
// Events are held one deep so last_event can be marked, then pass through an
// output register; a stalled receiver holds the sequencer at its next event.
// Reset (synchronous, active low) empties the table, clears time to zero and
// marks no job as running; the block is ready the cycle after reset.
`default_nettype none
module edf_job_scheduler import edf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [31:0]       r_now, n_now;
    logic              r_run_v, n_run_v;
    logic [SLOT_W-1:0] r_run_idx, n_run_idx;
    logic [SLOT_W-1:0] r_best_idx;
    t_in_item          r_cmd;
    logic              r_pend_v, n_pend_v;
    t_out_item         r_pend, n_pend;
    logic              r_out_v, n_out_v;
    t_out_item         r_out, n_out;

    t_cell_ctl         ctl;
    t_best             chain [NUM_SLOTS+1];
    t_view             views [NUM_SLOTS];
    t_view             sv;
    logic [SLOT_W-1:0] sel_idx;

    logic              ev_fire;
    t_out_item         ev;
    logic              flush;
    logic              out_free;
    logic              adv;
    logic              miss;
    logic              free_v;
    logic [SLOT_W-1:0] free_idx;
    logic [32:0]       dl_sum;
    logic              rel_ok;
    logic              in_acc;

    assign chain[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        edf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_ctl   (ctl),
            .i_best  (chain[g]),
            .o_best  (chain[g+1]),
            .o_view  (views[g])
        );
    end

    assign sv       = views[sel_idx];
    assign miss     = sv.valid && (sv.dl <= r_now);
    assign out_free = !r_out_v || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (!views[k].valid) begin
                free_v   = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    assign dl_sum = {1'b0, r_now} + {17'd0, r_cmd.rel_deadline};
    assign rel_ok = free_v && (r_cmd.exec_time != 16'd0);

    // outputs of the sequencer
    always_comb begin
        ev_fire            = 1'b0;
        flush              = 1'b0;
        sel_idx            = r_pos;
        ev                 = '0;
        ev.event_time      = r_now;
        o_in_ready         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_REL: begin
                ev_fire        = 1'b1;
                ev.event_task  = r_cmd.task_id;
                ev.remaining_out = r_cmd.exec_time;
                if (rel_ok) begin
                    ev.event_kind = EV_ACCEPTED;
                    ev.slot_index = 4'(free_idx);
                end else begin
                    ev.event_kind = EV_REJECTED;
                end
            end
            ST_SCAN: begin
                sel_idx = r_pos;
                if (miss) begin
                    ev_fire          = 1'b1;
                    ev.event_kind    = EV_MISS;
                    ev.slot_index    = 4'(r_pos);
                    ev.event_task    = sv.task_id;
                    ev.remaining_out = sv.rem;
                    ev.waiting_out   = sv.dl - sv.rel - ({16'd0, sv.exec} - {16'd0, sv.rem});
                end
            end
            ST_IDLE_EV: begin
                ev_fire       = 1'b1;
                ev.event_kind = EV_IDLE;
            end
            ST_PRE: begin
                sel_idx          = r_run_idx;
                ev_fire          = 1'b1;
                ev.event_kind    = EV_PREEMPT;
                ev.slot_index    = 4'(r_run_idx);
                ev.event_task    = sv.task_id;
                ev.remaining_out = sv.rem;
            end
            ST_START: begin
                sel_idx          = r_best_idx;
                ev_fire          = 1'b1;
                ev.event_kind    = sv.started ? EV_RESUME : EV_START;
                ev.slot_index    = 4'(r_best_idx);
                ev.event_task    = sv.task_id;
                ev.remaining_out = sv.rem;
            end
            ST_RUN: begin
                sel_idx = r_best_idx;
            end
            ST_FIN: begin
                sel_idx        = r_best_idx;
                ev_fire        = 1'b1;
                ev.event_kind  = EV_FINISH;
                ev.slot_index  = 4'(r_best_idx);
                ev.event_task  = sv.task_id;
                ev.waiting_out = r_now - sv.rel - {16'd0, sv.exec};
            end
            ST_FLUSH: begin
                flush = r_pend_v;
            end
            default: begin
                sel_idx = r_pos;
            end
        endcase
    end

    assign adv = ev_fire ? (!r_pend_v || out_free) : (flush ? out_free : 1'b1);

    always_comb begin
        ctl         = '0;
        ctl.pos     = r_pos;
        ctl.now     = r_now;
        ctl.run_v   = r_run_v;
        ctl.run_idx = r_run_idx;
        ctl.tgt_idx = r_best_idx;
        ctl.wr_task = r_cmd.task_id;
        ctl.wr_exec = r_cmd.exec_time;
        ctl.wr_dl   = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
        case (r_state)
            ST_REL: begin
                ctl.tgt_idx = free_idx;
                ctl.wr      = adv && rel_ok;
            end
            ST_SCAN:  ctl.scan  = adv;
            ST_START: ctl.start = adv;
            ST_RUN:   ctl.dec   = 1'b1;
            ST_FIN:   ctl.clr   = adv;
            default:  ctl.scan  = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.command == CMD_TICK) ? ST_SCAN : ST_REL;
                end
            end
            ST_REL: begin
                if (adv) n_state = ST_FLUSH;
            end
            ST_SCAN: begin
                if (adv && r_pos == SLOT_W'(NUM_SLOTS - 1)) n_state = ST_PICK;
            end
            ST_PICK: begin
                if (!chain[NUM_SLOTS].v) begin
                    n_state = ST_IDLE_EV;
                end else if (r_run_v && chain[NUM_SLOTS].idx == r_run_idx) begin
                    n_state = ST_RUN;
                end else if (r_run_v) begin
                    n_state = ST_PRE;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_IDLE_EV: begin
                if (adv) n_state = ST_FLUSH;
            end
            ST_PRE: begin
                if (adv) n_state = ST_START;
            end
            ST_START: begin
                if (adv) n_state = ST_RUN;
            end
            ST_RUN: begin
                n_state = (sv.rem == 16'd1) ? ST_FIN : ST_FLUSH;
            end
            ST_FIN: begin
                if (adv) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (adv) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_pos     = r_pos;
        n_now     = r_now;
        n_run_v   = r_run_v;
        n_run_idx = r_run_idx;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out_v   = r_out_v;
        n_out     = r_out;
        if (r_out_v && i_out_ready) n_out_v = 1'b0;
        if (adv && ev_fire) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend_v = 1'b1;
            n_pend   = ev;
        end
        if (adv && flush) begin
            n_out_v            = 1'b1;
            n_out              = r_pend;
            n_out.last_event   = 1'b1;
            n_pend_v           = 1'b0;
        end
        case (r_state)
            ST_IDLE: n_pos = '0;
            ST_SCAN: begin
                if (adv) begin
                    n_pos = r_pos + SLOT_W'(1);
                    if (miss && r_run_v && r_run_idx == r_pos) n_run_v = 1'b0;
                end
            end
            ST_IDLE_EV: begin
                if (adv) begin
                    n_now   = r_now + 32'd1;
                    n_run_v = 1'b0;
                end
            end
            ST_START: begin
                if (adv) begin
                    n_run_v   = 1'b1;
                    n_run_idx = r_best_idx;
                end
            end
            ST_RUN: n_now = r_now + 32'd1;
            ST_FIN: begin
                if (adv) n_run_v = 1'b0;
            end
            default: n_pos = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_now     <= '0;
            r_run_v   <= 1'b0;
            r_run_idx <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_now     <= n_now;
            r_run_v   <= n_run_v;
            r_run_idx <= n_run_idx;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (in_acc) r_cmd <= i_in_data;
        if (r_state == ST_PICK) r_best_idx <= chain[NUM_SLOTS].idx;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the EDF job scheduler: directed table, then random traffic
// checked against a behavioral predictor.
module tb import edf_pkg::*;;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        t_in_item item;
        bit       typed;
        t_evk     kind;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    edf_job_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // scheduler shadow state
    logic [31:0] now_t;
    bit          sv_valid [NUM_SLOTS];
    logic [7:0]  sv_task  [NUM_SLOTS];
    logic [15:0] sv_exec  [NUM_SLOTS];
    logic [15:0] sv_rem   [NUM_SLOTS];
    logic [31:0] sv_rel   [NUM_SLOTS];
    logic [31:0] sv_dl    [NUM_SLOTS];
    bit          sv_start [NUM_SLOTS];
    int          run_slot;

    t_out_item event_q[$];
    bit        typed_q[$];
    t_evk      kind_q[$];
    t_row      rows[$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        cycles = 0;
    bit        failed = 1'b0;

    function automatic bit wins(int a, int b);
        if (sv_dl[a] != sv_dl[b]) return sv_dl[a] < sv_dl[b];
        if (b == run_slot) return 1'b0;
        if (a == run_slot) return 1'b1;
        return sv_rel[a] > sv_rel[b];
    endfunction

    function automatic void add_event(t_evk k, int s, logic [7:0] tk, logic [15:0] rem,
                                      logic [31:0] w);
        t_out_item e;
        e.event_kind    = k;
        e.slot_index    = s[3:0];
        e.event_task    = tk;
        e.event_time    = now_t;
        e.remaining_out = rem;
        e.waiting_out   = w;
        e.last_event    = 1'b0;
        event_q.insert(event_q.size(), e);
    endfunction

    function automatic void add_row(t_in_item it, bit typed, t_evk kind);
        t_row r;
        r.item  = it;
        r.typed = typed;
        r.kind  = kind;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void schedule_events(t_in_item it);
        int slot;
        int best;
        int n0;
        logic [31:0] dl;
        n0 = event_q.size();
        if (it.command == CMD_RELEASE) begin
            slot = NUM_SLOTS;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
                if (!sv_valid[i]) slot = i;
            if (slot == NUM_SLOTS || it.exec_time == 0) begin
                add_event(EV_REJECTED, 0, it.task_id, it.exec_time, 0);
            end else begin
                dl = now_t + it.rel_deadline;
                if (dl < now_t) dl = 32'hFFFF_FFFF;
                sv_valid[slot] = 1'b1;
                sv_task[slot]  = it.task_id;
                sv_exec[slot]  = it.exec_time;
                sv_rem[slot]   = it.exec_time;
                sv_rel[slot]   = now_t;
                sv_dl[slot]    = dl;
                sv_start[slot] = 1'b0;
                add_event(EV_ACCEPTED, slot, it.task_id, it.exec_time, 0);
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (sv_valid[i] && sv_dl[i] <= now_t) begin
                    add_event(EV_MISS, i, sv_task[i], sv_rem[i],
                              sv_dl[i] - sv_rel[i] - (32'(sv_exec[i]) - 32'(sv_rem[i])));
                    sv_valid[i] = 1'b0;
                    if (run_slot == i) run_slot = NUM_SLOTS;
                end
            end
            best = NUM_SLOTS;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (sv_valid[i] && (best == NUM_SLOTS || wins(i, best))) best = i;
            if (best == NUM_SLOTS) begin
                add_event(EV_IDLE, 0, 0, 0, 0);
                run_slot = NUM_SLOTS;
                now_t++;
            end else begin
                if (best != run_slot) begin
                    if (run_slot < NUM_SLOTS && sv_valid[run_slot])
                        add_event(EV_PREEMPT, run_slot, sv_task[run_slot], sv_rem[run_slot], 0);
                    add_event(sv_start[best] ? EV_RESUME : EV_START, best, sv_task[best],
                              sv_rem[best], 0);
                    sv_start[best] = 1'b1;
                    run_slot = best;
                end
                if (sv_rem[best] > 0) sv_rem[best]--;
                now_t++;
                if (sv_rem[best] == 0) begin
                    add_event(EV_FINISH, best, sv_task[best], 0,
                              now_t - sv_rel[best] - 32'(sv_exec[best]));
                    sv_valid[best] = 1'b0;
                    run_slot = NUM_SLOTS;
                end
            end
        end
        if (event_q.size() > n0) event_q[event_q.size() - 1].last_event = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp, act);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            int n0;
            n0 = event_q.size();
            schedule_events(i_in_data);
            if (typed_q.pop_front() && event_q.size() > n0) event_q[n0].event_kind = kind_q[0];
            void'(kind_q.pop_front());
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (event_q.size() == 0) begin
                $display("%0t unexpected transfer out: %p", $time, o_out_data);
                failed = 1'b1;
            end else begin
                e = event_q.pop_front();
                check_field("event_kind", e.event_kind, o_out_data.event_kind);
                check_field("slot_index", e.slot_index, o_out_data.slot_index);
                check_field("event_task", e.event_task, o_out_data.event_task);
                check_field("event_time", e.event_time, o_out_data.event_time);
                check_field("remaining_out", e.remaining_out, o_out_data.remaining_out);
                check_field("waiting_out", e.waiting_out, o_out_data.waiting_out);
                check_field("last_event", e.last_event, o_out_data.last_event);
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(t_in_item it, bit typed, t_evk kind);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        typed_q.insert(typed_q.size(), typed);
        kind_q.insert(kind_q.size(), kind);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic cmd, logic [7:0] tk, logic [15:0] ex,
                                    logic [15:0] rd);
        t_in_item it;
        it.command = cmd;
        it.task_id = tk;
        it.exec_time = ex;
        it.rel_deadline = rd;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.command = ($urandom_range(99) < 45) ? CMD_RELEASE : CMD_TICK;
        it.task_id = 8'($urandom);
        case ($urandom_range(19))
            0:       it.exec_time = 16'($urandom);
            1:       it.exec_time = 16'd0;
            default: it.exec_time = 16'($urandom_range(6, 1));
        endcase
        if ($urandom_range(19) == 0) it.rel_deadline = 16'($urandom);
        else it.rel_deadline = 16'($urandom_range(40, 1));
        return it;
    endfunction

    initial begin
        now_t = 0;
        run_slot = NUM_SLOTS;
        foreach (sv_valid[i]) sv_valid[i] = 1'b0;

        add_row(mk(CMD_TICK, 0, 0, 0), 1'b1, EV_IDLE);
        add_row(mk(CMD_RELEASE, 8'd5, 16'd0, 16'd9), 1'b1, EV_REJECTED);
        add_row(mk(CMD_RELEASE, 8'd0, 16'd1, 16'd1), 1'b1, EV_ACCEPTED);
        add_row(mk(CMD_TICK, 0, 0, 0), 1'b0, EV_START);
        add_row(mk(CMD_RELEASE, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b1, EV_ACCEPTED);
        add_row(mk(CMD_TICK, 0, 0, 0), 1'b0, EV_START);
        add_row(mk(CMD_RELEASE, 8'd1, 16'd2, 16'd1), 1'b1, EV_ACCEPTED);
        add_row(mk(CMD_TICK, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b0, EV_START);
        add_row(mk(CMD_TICK, 0, 0, 0), 1'b0, EV_START);
        add_row(mk(CMD_RELEASE, 8'd2, 16'd3, 16'd50), 1'b1, EV_ACCEPTED);
        add_row(mk(CMD_RELEASE, 8'd3, 16'd3, 16'd50), 1'b1, EV_ACCEPTED);
        add_row(mk(CMD_TICK, 0, 0, 0), 1'b0, EV_START);
        add_row(mk(CMD_TICK, 0, 0, 0), 1'b0, EV_START);
        for (int i = 0; i < 14; i++)
            add_row(mk(CMD_RELEASE, 8'(16 + i), 16'd4, 16'd60), 1'b0, EV_ACCEPTED);
        add_row(mk(CMD_RELEASE, 8'hAA, 16'h5555, 16'd7), 1'b1, EV_REJECTED);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send(rows[r].item, rows[r].typed, rows[r].kind);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (int k = 0; k < 30; k++) send(rand_item(), 1'b0, EV_START);
        end
        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (event_q.size() != 0 || typed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (!failed && event_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/edf_pkg.sv
src/edf_cell.sv
src/edf_job_scheduler.sv
verif/tb.sv
